FILE: rtl/pbed_pkg.sv
`default_nettype none
package pbed_pkg;

    localparam int unsigned MaxEvents = 3;

    typedef enum logic [3:0] {
        EV_OK_END      = 4'd0,
        EV_ERR_END     = 4'd1,
        EV_CODE        = 4'd2,
        EV_SECS        = 4'd3,
        EV_NANOS       = 4'd4,
        EV_LIMIT       = 4'd5,
        EV_REMAINING   = 4'd6,
        EV_RESET       = 4'd7,
        EV_STR_BEGIN   = 4'd8,
        EV_STR_BYTE    = 4'd9,
        EV_DUR_SEEN    = 4'd10,
        EV_RL_SEEN     = 4'd11
    } t_kind;

    typedef enum logic [2:0] {
        PH_TAG    = 3'd0,
        PH_VARINT = 3'd1,
        PH_LENGTH = 3'd2,
        PH_STRING = 3'd3,
        PH_SKIP   = 3'd4
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [1:0]  slot;
    } t_event;

    typedef struct packed {
        logic [1:0] count;
        t_event     ev0;
        t_event     ev1;
        t_event     ev2;
    } t_bundle;

    localparam int unsigned BundleW = $bits(t_bundle);

    // strict utf-8 step, returns 4'hf on error
    function automatic logic [3:0] utf8_next(input logic [2:0] st, input logic [7:0] b);
        logic cont;
        cont = (b >= 8'h80) && (b <= 8'hbf);
        utf8_next = 4'hf;
        case (st)
            3'd0: begin
                if (b < 8'h80) utf8_next = 4'd0;
                else if (b >= 8'hc2 && b <= 8'hdf) utf8_next = 4'd1;
                else if (b == 8'he0) utf8_next = 4'd4;
                else if (b == 8'hed) utf8_next = 4'd5;
                else if (b >= 8'he1 && b <= 8'hef) utf8_next = 4'd2;
                else if (b == 8'hf0) utf8_next = 4'd6;
                else if (b >= 8'hf1 && b <= 8'hf3) utf8_next = 4'd3;
                else if (b == 8'hf4) utf8_next = 4'd7;
            end
            3'd1: if (cont) utf8_next = 4'd0;
            3'd2: if (cont) utf8_next = 4'd1;
            3'd3: if (cont) utf8_next = 4'd2;
            3'd4: if (b >= 8'ha0 && b <= 8'hbf) utf8_next = 4'd1;
            3'd5: if (b >= 8'h80 && b <= 8'h9f) utf8_next = 4'd1;
            3'd6: if (b >= 8'h90 && b <= 8'hbf) utf8_next = 4'd2;
            3'd7: if (b >= 8'h80 && b <= 8'h8f) utf8_next = 4'd2;
            default: utf8_next = 4'hf;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pbed_front.sv
`default_nettype none
module pbed_front #(
    parameter int unsigned MAX_LEN = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_last,
    output pbed_pkg::t_bundle      o_bundle
);
    localparam int unsigned RemW = 17;
    localparam logic [63:0] MaxLen64 = 64'(MAX_LEN);

    logic [1:0]        r_nest, n_nest;
    pbed_pkg::t_phase  r_phase, n_phase;
    logic [63:0]       r_acc, n_acc;
    logic [3:0]        r_cnt, n_cnt;
    logic [31:0]       r_fn, n_fn;
    logic [RemW-1:0]   r_sub, n_sub;
    logic [RemW-1:0]   r_pay, n_pay;
    logic [2:0]        r_utf, n_utf;
    logic              r_fail, n_fail;
    logic [1:0]        r_slot, n_slot;

    pbed_pkg::t_bundle b;
    pbed_pkg::t_event  evs [pbed_pkg::MaxEvents];
    logic [1:0]        ne;
    logic              ok;
    logic              nested;
    logic              vdone, verr;
    logic [63:0]       v, acc_add;
    logic [5:0]        shamt;
    logic [3:0]        u;
    logic              clean;

    always_comb begin
        n_nest = r_nest; n_phase = r_phase; n_acc = r_acc; n_cnt = r_cnt;
        n_fn = r_fn; n_sub = r_sub; n_pay = r_pay; n_utf = r_utf;
        n_fail = r_fail; n_slot = r_slot;
        ne = 2'd0; ok = 1'b1; clean = 1'b0;
        for (int k = 0; k < 3; k++) begin
            evs[k] = '{kind: pbed_pkg::EV_OK_END, value: 64'd0, slot: 2'd0};
        end
        nested = (r_nest != 2'd0);
        shamt = (r_cnt >= 4'd9) ? 6'd63 : 6'(7 * r_cnt);
        acc_add = 64'(i_byte[6:0]) << shamt;
        v = r_acc | acc_add;
        verr = (r_cnt >= 4'd9) && ((i_byte & 8'hfe) != 8'd0);
        vdone = !i_byte[7];
        u = pbed_pkg::utf8_next(r_utf, i_byte);
        if (!r_fail) begin
            if (nested) n_sub = r_sub - RemW'(1);
            unique case (r_phase) inside
                pbed_pkg::PH_TAG, pbed_pkg::PH_VARINT, pbed_pkg::PH_LENGTH: begin
                    if (verr) ok = 1'b0;
                    else if (!vdone) begin
                        n_acc = v; n_cnt = r_cnt + 4'd1;
                    end else begin
                        n_acc = 64'd0; n_cnt = 4'd0;
                        if (r_phase == pbed_pkg::PH_TAG) begin
                            if (v == 64'd0) ok = 1'b0;
                            else begin
                                n_fn = v[34:3];
                                if (v[2:0] == 3'd0) n_phase = pbed_pkg::PH_VARINT;
                                else if (v[2:0] == 3'd2) n_phase = pbed_pkg::PH_LENGTH;
                                else if (v[2:0] == 3'd1 || v[2:0] == 3'd5) begin
                                    n_pay = (v[2:0] == 3'd1) ? RemW'(8) : RemW'(4);
                                    if (nested && n_pay > n_sub) ok = 1'b0;
                                    n_phase = pbed_pkg::PH_SKIP;
                                end else ok = 1'b0;
                            end
                        end else if (r_phase == pbed_pkg::PH_VARINT) begin
                            n_phase = pbed_pkg::PH_TAG;
                            if (r_nest == 2'd0) begin
                                if (r_fn == 32'd2) begin
                                    if (v > 64'h7fffffff) ok = 1'b0;
                                    else begin
                                        evs[0] = '{kind: pbed_pkg::EV_CODE, value: v, slot: 2'd0};
                                        ne = 2'd1;
                                    end
                                end
                            end else if (r_nest == 2'd1) begin
                                if (r_fn == 32'd1) begin
                                    evs[0] = '{kind: pbed_pkg::EV_SECS, value: v, slot: 2'd0};
                                    ne = 2'd1;
                                end else if (r_fn == 32'd2) begin
                                    if (v > 64'hffffffff) ok = 1'b0;
                                    else begin
                                        evs[0] = '{kind: pbed_pkg::EV_NANOS, value: v,
                                                   slot: 2'd0};
                                        ne = 2'd1;
                                    end
                                end
                            end else if (r_fn >= 32'd1 && r_fn <= 32'd3) begin
                                evs[0] = '{kind: pbed_pkg::t_kind'(4'd4 + r_fn[3:0]),
                                           value: v, slot: 2'd0};
                                ne = 2'd1;
                            end
                        end else begin
                            if (v > MaxLen64) ok = 1'b0;
                            else if (!nested && (r_fn == 32'd1 || r_fn == 32'd3 ||
                                                 r_fn == 32'd4 || r_fn == 32'd5)) begin
                                n_slot = (r_fn == 32'd1) ? 2'd0 : 2'(r_fn - 32'd2);
                                n_utf = 3'd0;
                                evs[0] = '{kind: pbed_pkg::EV_STR_BEGIN, value: v,
                                           slot: n_slot};
                                ne = 2'd1;
                                n_pay = RemW'(v);
                                n_phase = (v == 64'd0) ? pbed_pkg::PH_TAG
                                                       : pbed_pkg::PH_STRING;
                            end else if (!nested && (r_fn == 32'd6 || r_fn == 32'd7)) begin
                                n_phase = pbed_pkg::PH_TAG;
                                if (v == 64'd0) begin
                                    evs[0] = '{kind: (r_fn == 32'd6) ? pbed_pkg::EV_DUR_SEEN
                                                                    : pbed_pkg::EV_RL_SEEN,
                                               value: 64'd0, slot: 2'd0};
                                    ne = 2'd1;
                                end else begin
                                    n_nest = 2'(r_fn - 32'd5);
                                    n_sub = RemW'(v);
                                end
                            end else begin
                                if (nested && v > 64'(n_sub)) ok = 1'b0;
                                n_pay = RemW'(v);
                                n_phase = (v == 64'd0) ? pbed_pkg::PH_TAG
                                                       : pbed_pkg::PH_SKIP;
                            end
                        end
                    end
                end
                pbed_pkg::PH_STRING: begin
                    if (u == 4'hf) ok = 1'b0;
                    else begin
                        n_utf = u[2:0];
                        evs[0] = '{kind: pbed_pkg::EV_STR_BYTE, value: 64'(i_byte),
                                   slot: r_slot};
                        ne = 2'd1;
                        n_pay = r_pay - RemW'(1);
                        if (n_pay == '0) begin
                            if (u != 4'd0) ok = 1'b0;
                            n_phase = pbed_pkg::PH_TAG;
                        end
                    end
                end
                default: begin
                    if (r_pay != '0) n_pay = r_pay - RemW'(1);
                    if (n_pay == '0) n_phase = pbed_pkg::PH_TAG;
                end
            endcase
            if (ok && nested && n_sub == '0) begin
                if (n_phase != pbed_pkg::PH_TAG || n_cnt != 4'd0) ok = 1'b0;
                else begin
                    evs[ne] = '{kind: (r_nest == 2'd1) ? pbed_pkg::EV_DUR_SEEN
                                                      : pbed_pkg::EV_RL_SEEN,
                                value: 64'd0, slot: 2'd0};
                    ne = ne + 2'd1;
                    n_nest = 2'd0;
                end
            end
            if (!ok) begin
                n_fail = 1'b1; ne = 2'd0;
            end
        end
        if (i_last) begin
            clean = !n_fail && n_nest == 2'd0 && n_phase == pbed_pkg::PH_TAG &&
                    n_cnt == 4'd0;
            evs[ne] = '{kind: clean ? pbed_pkg::EV_OK_END : pbed_pkg::EV_ERR_END,
                        value: 64'd0, slot: 2'd0};
            ne = ne + 2'd1;
        end
        b.count = ne;
        b.ev0 = evs[0];
        b.ev1 = evs[1];
        b.ev2 = evs[2];
    end

    assign o_bundle = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last)) begin
            r_nest <= 2'd0; r_phase <= pbed_pkg::PH_TAG; r_acc <= 64'd0; r_cnt <= 4'd0;
            r_fn <= 32'd0; r_sub <= '0; r_pay <= '0; r_utf <= 3'd0;
            r_fail <= 1'b0; r_slot <= 2'd0;
        end else if (i_valid) begin
            r_nest <= n_nest; r_phase <= n_phase; r_acc <= n_acc; r_cnt <= n_cnt;
            r_fn <= n_fn; r_sub <= n_sub; r_pay <= n_pay; r_utf <= n_utf;
            r_fail <= n_fail; r_slot <= n_slot;
        end
    end

    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fail && !i_last) |-> (b.count == 2'd0))
        else $error("events while failed");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_last |-> (b.count != 2'd0))
        else $error("last byte without end event");
    a_nest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nest != 2'd3)
        else $error("bad nest level");
endmodule
`default_nettype wire

FILE: rtl/pbed_queue.sv
`default_nettype none
module pbed_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire logic [pbed_pkg::BundleW-1:0] i_data,
    output logic                           o_full,
    input  wire logic                      i_pop,
    output logic                           o_empty,
    output logic [pbed_pkg::BundleW-1:0]   o_data
);
    localparam int unsigned AW = $clog2(DEPTH);

    logic [pbed_pkg::BundleW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (do_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> o_full)
        else $error("full dropped without pop");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !do_push) |=> o_empty)
        else $error("empty dropped without push");
endmodule
`default_nettype wire

FILE: rtl/pbed_back.sv
`default_nettype none
module pbed_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire pbed_pkg::t_bundle i_bundle,
    output logic                   o_q_pop,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [3:0]             o_kind,
    output logic [63:0]            o_value,
    output logic [1:0]             o_slot,
    output logic                   o_last
);
    logic [1:0] r_idx;
    logic       have;
    logic       last_ev;
    logic       take;
    pbed_pkg::t_event ev;

    // bundles with no event are dropped
    assign have    = !i_q_empty && (i_bundle.count != 2'd0);
    assign last_ev = (r_idx + 2'd1 == i_bundle.count);
    assign take    = have && i_pop;
    assign o_empty = !have;
    assign o_q_pop = (!i_q_empty && i_bundle.count == 2'd0) || (take && last_ev);

    always_comb begin
        case (r_idx)
            2'd0:    ev = i_bundle.ev0;
            2'd1:    ev = i_bundle.ev1;
            default: ev = i_bundle.ev2;
        endcase
    end

    assign o_kind  = ev.kind;
    assign o_value = ev.value;
    assign o_slot  = ev.slot;
    assign o_last  = last_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= last_ev ? 2'd0 : r_idx + 2'd1;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        have |-> (r_idx < i_bundle.count))
        else $error("event index past bundle");
    a_idx_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_empty |-> (r_idx == 2'd0))
        else $error("index left mid bundle");
    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && last_ev) |-> o_q_pop)
        else $error("bundle not released");
endmodule
`default_nettype wire

FILE: rtl/protobuf_error_details_decoder_unit.sv
`default_nettype none
// protobuf error-details stream decoder. one byte is taken per cycle while full
// is low; the front parser updates its state on each accepted byte and files up
// to three events per byte into a small queue, and the result side hands out one
// event per cycle while pop is high. sustained input rate is one byte a cycle as
// long as results are drained at least as fast as produced; a byte's events hold
// the result side until all are popped, a byte with none is dropped unseen, so
// the queue depth sets how long bursts run. a byte's first event reaches the
// result ports once its bundle, registered in the queue, is at the queue head.
module protobuf_error_details_decoder_unit #(
    parameter int unsigned MAX_LEN = 4096,
    parameter int unsigned QDEPTH  = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_message,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       o_event_kind,
    output logic [63:0]      o_event_value,
    output logic [1:0]       o_string_slot,
    output logic             o_last_of_run
);
    pbed_pkg::t_bundle f_bundle, q_bundle;
    logic              accept;
    logic              q_empty, q_pop;

    assign accept = push && !full;

    pbed_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_byte   (i_data_byte),
        .i_last   (i_end_of_message),
        .o_bundle (f_bundle)
    );

    pbed_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (f_bundle),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_bundle)
    );

    pbed_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_bundle  (q_bundle),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_kind    (o_event_kind),
        .o_value   (o_event_value),
        .o_slot    (o_string_slot),
        .o_last    (o_last_of_run)
    );
endmodule
`default_nettype wire
